// ===== src/ldsd_pkg.sv =====
// Shared types and schedule tables for the LED daylight schedule dimmer.
// Used by ldsd_lane, the top level and the port checker; no dependencies.
`default_nettype none

package ldsd_pkg;

  localparam int SEG_COUNT  = 17;
  localparam int CHAN_COUNT = 4;
  localparam int PIPE_DEPTH = 8;

  localparam int MIN_W   = 11;
  localparam int DUTY_W  = 8;
  localparam int OFF_W   = 9;
  localparam int IDX_W   = 5;
  localparam int RECIP_W = 21;
  localparam int RECIP_SHIFT = 25;

  localparam logic [MIN_W-1:0] LAST_MINUTE = 11'd1439;
  localparam logic [8:0]       HALF_POT_SPAN = 9'd511;

  // Channel order inside the duty tables.
  localparam int CH_RED    = 0;
  localparam int CH_WHITE  = 1;
  localparam int CH_BLUE   = 2;
  localparam int CH_VIOLET = 3;

  typedef struct packed {
    logic [9:0] pot_reading;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
  } item_t;

  typedef struct packed {
    logic [MIN_W-1:0]  minute_of_day;
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] white_duty;
    logic [DUTY_W-1:0] blue_duty;
    logic [DUTY_W-1:0] violet_duty;
    logic              manual_mode;
  } result_t;

  // Operands handed to one interpolation lane.
  typedef struct packed {
    logic [OFF_W-1:0]   offset;
    logic [RECIP_W-1:0] recip;
    logic [DUTY_W-1:0]  start_duty;
    logic [DUTY_W-1:0]  delta_mag;
    logic               delta_neg;
  } lane_in_t;

  // First minute of each segment.
  localparam logic [MIN_W-1:0] SEG_LO [SEG_COUNT] = '{
    11'd0,    11'd61,   11'd480,  11'd510,  11'd540,  11'd570,
    11'd600,  11'd660,  11'd1080, 11'd1140, 11'd1170, 11'd1200,
    11'd1230, 11'd1260, 11'd1290, 11'd1320, 11'd1380
  };

  // ceil(2^25 / span) for each segment; exact floor division for the
  // products that occur in that segment.
  localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_COUNT] = '{
    21'd559241,  21'd80274,   21'd1157050, 21'd1157050, 21'd1157050,
    21'd1157050, 21'd568720,  21'd80083,   21'd568720,  21'd1157050,
    21'd1157050, 21'd1157050, 21'd1157050, 21'd1157050, 21'd1157050,
    21'd568720,  21'd568720
  };

  // Start duty per segment, channels red, white, blue, violet.
  localparam logic [DUTY_W-1:0] SEG_D0 [SEG_COUNT][CHAN_COUNT] = '{
    '{8'd25,  8'd25,  8'd30,  8'd30},
    '{8'd0,   8'd0,   8'd25,  8'd25},
    '{8'd0,   8'd0,   8'd10,  8'd10},
    '{8'd20,  8'd10,  8'd0,   8'd5},
    '{8'd25,  8'd25,  8'd10,  8'd10},
    '{8'd35,  8'd35,  8'd35,  8'd35},
    '{8'd60,  8'd60,  8'd60,  8'd60},
    '{8'd100, 8'd100, 8'd100, 8'd100},
    '{8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd150, 8'd150, 8'd150, 8'd150},
    '{8'd125, 8'd125, 8'd125, 8'd125},
    '{8'd110, 8'd110, 8'd110, 8'd110},
    '{8'd100, 8'd100, 8'd100, 8'd100},
    '{8'd100, 8'd80,  8'd80,  8'd80},
    '{8'd90,  8'd70,  8'd70,  8'd70},
    '{8'd70,  8'd50,  8'd50,  8'd50},
    '{8'd50,  8'd40,  8'd40,  8'd40}
  };

  // End duty per segment, same channel order.
  localparam logic [DUTY_W-1:0] SEG_D1 [SEG_COUNT][CHAN_COUNT] = '{
    '{8'd0,   8'd0,   8'd25,  8'd25},
    '{8'd0,   8'd0,   8'd10,  8'd10},
    '{8'd20,  8'd10,  8'd0,   8'd5},
    '{8'd25,  8'd25,  8'd10,  8'd10},
    '{8'd35,  8'd35,  8'd35,  8'd35},
    '{8'd60,  8'd60,  8'd60,  8'd60},
    '{8'd100, 8'd100, 8'd100, 8'd100},
    '{8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd150, 8'd150, 8'd150, 8'd150},
    '{8'd125, 8'd125, 8'd125, 8'd125},
    '{8'd110, 8'd110, 8'd110, 8'd110},
    '{8'd100, 8'd100, 8'd100, 8'd100},
    '{8'd100, 8'd80,  8'd80,  8'd80},
    '{8'd90,  8'd70,  8'd70,  8'd70},
    '{8'd70,  8'd50,  8'd50,  8'd50},
    '{8'd50,  8'd40,  8'd40,  8'd40},
    '{8'd25,  8'd25,  8'd30,  8'd30}
  };

endpackage

`default_nettype wire

// ===== src/ldsd_lane.sv =====
// One channel's interpolation: three register stages of multiply,
// reciprocal multiply and offset. Depends on ldsd_pkg.
`default_nettype none

module ldsd_lane
  import ldsd_pkg::*;
(
  input  wire logic              clk,
  input  wire lane_in_t          lane,
  output logic [DUTY_W-1:0]      duty
);

  localparam int PROD_W = OFF_W + DUTY_W;
  localparam int FULL_W = PROD_W + RECIP_W;

  logic [PROD_W-1:0]  prod;
  logic [RECIP_W-1:0] recip;
  logic [DUTY_W-1:0]  base_a;
  logic [DUTY_W-1:0]  base_b;
  logic               neg_a;
  logic               neg_b;
  logic [DUTY_W-1:0]  quot;
  logic [FULL_W-1:0]  quot_full;
  logic [DUTY_W:0]    duty_next;

  assign quot_full = {{RECIP_W{1'b0}}, prod} * {{PROD_W{1'b0}}, recip};

  always_comb begin
    if (neg_b) begin
      duty_next = {1'b0, base_b} - {1'b0, quot};
    end else begin
      duty_next = {1'b0, base_b} + {1'b0, quot};
    end
  end

  always_ff @(posedge clk) begin
    // offset times magnitude of the duty change
    prod   <= {{DUTY_W{1'b0}}, lane.offset} * {{OFF_W{1'b0}}, lane.delta_mag};
    recip  <= lane.recip;
    base_a <= lane.start_duty;
    neg_a  <= lane.delta_neg;
    // truncating divide by span on the magnitude
    quot   <= quot_full[RECIP_SHIFT +: DUTY_W];
    base_b <= base_a;
    neg_b  <= neg_a;
    duty   <= duty_next[DUTY_W-1:0];
  end

endmodule

`default_nettype wire

// ===== src/led_daylight_schedule_dimmer.sv =====
// Top level of the LED daylight schedule dimmer: minute selection, segment
// lookup and four interpolation lanes. Depends on ldsd_pkg and ldsd_lane.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------
//   item    | in        | start, busy      | item_t: pot, hour, minute
//   result  | out       | done (strobe)    | result_t: minute, 4 duties,
//           |           |                  | manual flag
//
// Each item passes from acceptance to its done strobe through the eight
// register stages of the datapath (PIPE_DEPTH); one item enters per cycle
// and busy stays low. Reset clears only the valid bits that travel with
// the data. The receiver cannot hold a result off, so nothing in the
// pipeline ever stalls: each result shows for exactly one cycle.
`default_nettype none

module led_daylight_schedule_dimmer
  import ldsd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire item_t   item,
  output logic         done,
  output result_t      result
);

  // Valid bits, one per stage; bit 0 is stage 1.
  logic [PIPE_DEPTH-1:0] vld;

  // Stage 1: override product and clock minute.
  logic [20:0]      s1_prod;
  logic [MIN_W-1:0] s1_clk_min;
  logic             s1_manual;
  logic [9:0]       pot_m1;
  logic [MIN_W-1:0] clk_raw;
  logic [MIN_W-1:0] clk_sat;

  // Stage 2: estimate of the override quotient.
  logic [19:0]      s2_y;
  logic [MIN_W-1:0] s2_q0;
  logic [MIN_W-1:0] s2_clk_min;
  logic             s2_manual;
  logic [19:0]      y_half;
  logic [19:0]      y_est;

  // Stage 3: minute of day.
  logic [MIN_W-1:0] s3_min;
  logic             s3_manual;
  logic [20:0]      rem_full;
  logic [MIN_W-1:0] pot_min;

  // Stage 4: segment index.
  logic [MIN_W-1:0] s4_min;
  logic             s4_manual;
  logic [IDX_W-1:0] s4_idx;
  logic [IDX_W-1:0] seg_sel;

  // Stage 5: lane operands; stages 6 to 8 carry minute and flag alongside.
  lane_in_t         s5_lane [CHAN_COUNT];
  logic [MIN_W-1:0] off_full;
  logic [MIN_W-1:0] s5_min;
  logic             s5_manual;
  logic [MIN_W-1:0] s6_min;
  logic             s6_manual;
  logic [MIN_W-1:0] s7_min;
  logic             s7_manual;
  logic [MIN_W-1:0] s8_min;
  logic             s8_manual;

  logic [DUTY_W-1:0] lane_duty [CHAN_COUNT];

  // The pipeline never refuses an item.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start & ~busy};
    end
  end

  // --- Stage 1 -----------------------------------------------------------
  // Override: minute = (pot - 1) * 1439 / 1022. Form the product here.
  // Clock: hour * 60 + minute, saturated to the last minute of the day.
  assign pot_m1  = item.pot_reading - 10'd1;
  assign clk_raw = ({6'b0, item.clock_hour} << 6) - ({6'b0, item.clock_hour} << 2)
                   + {5'b0, item.clock_minute};
  assign clk_sat = (clk_raw > LAST_MINUTE) ? LAST_MINUTE : clk_raw;

  always_ff @(posedge clk) begin
    s1_prod    <= {11'b0, pot_m1} * {10'b0, LAST_MINUTE};
    s1_clk_min <= clk_sat;
    s1_manual  <= (item.pot_reading != 10'd0);
  end

  // --- Stage 2 -----------------------------------------------------------
  // Divide by 1022 as halve, then divide by 511 = 2^9 - 1. The series
  // y/512 + y/512^2 + y/512^3 undershoots y/511 by less than one.
  assign y_half = s1_prod[20:1];
  assign y_est  = y_half + (y_half >> 9) + (y_half >> 18);

  always_ff @(posedge clk) begin
    s2_y       <= y_half;
    s2_q0      <= y_est[19:9];
    s2_clk_min <= s1_clk_min;
    s2_manual  <= s1_manual;
  end

  // --- Stage 3 -----------------------------------------------------------
  // Remainder y - 511 * q0 lies below 1022; bump the quotient once if it
  // reaches 511.
  assign rem_full = {1'b0, s2_y} - {1'b0, s2_q0, 9'b0} + {10'b0, s2_q0};
  assign pot_min  = (rem_full[MIN_W-1:0] >= {2'b0, HALF_POT_SPAN}) ?
                    s2_q0 + 11'd1 : s2_q0;

  always_ff @(posedge clk) begin
    s3_min    <= s2_manual ? pot_min : s2_clk_min;
    s3_manual <= s2_manual;
  end

  // --- Stage 4 -----------------------------------------------------------
  // Segments are sorted and cover the day: take the last start not above m.
  always_comb begin
    seg_sel = '0;
    for (int s = 1; s < SEG_COUNT; s++) begin
      if (s3_min >= SEG_LO[s]) begin
        seg_sel = IDX_W'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    s4_min    <= s3_min;
    s4_manual <= s3_manual;
    s4_idx    <= seg_sel;
  end

  // --- Stage 5 -----------------------------------------------------------
  // Fetch the segment's start minute, reciprocal and duties; split each duty
  // change into magnitude and sign so the lanes divide on magnitudes only.
  assign off_full = s4_min - SEG_LO[s4_idx];

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHAN_COUNT; c++) begin
      s5_lane[c].offset     <= off_full[OFF_W-1:0];
      s5_lane[c].recip      <= SEG_RECIP[s4_idx];
      s5_lane[c].start_duty <= SEG_D0[s4_idx][c];
      s5_lane[c].delta_neg  <= (SEG_D1[s4_idx][c] < SEG_D0[s4_idx][c]);
      s5_lane[c].delta_mag  <= (SEG_D1[s4_idx][c] < SEG_D0[s4_idx][c]) ?
                               SEG_D0[s4_idx][c] - SEG_D1[s4_idx][c] :
                               SEG_D1[s4_idx][c] - SEG_D0[s4_idx][c];
    end
    s5_min    <= s4_min;
    s5_manual <= s4_manual;
  end

  // --- Stages 6 to 8 -----------------------------------------------------
  for (genvar g = 0; g < CHAN_COUNT; g++) begin : g_lane
    ldsd_lane u_lane (
      .clk  (clk),
      .lane (s5_lane[g]),
      .duty (lane_duty[g])
    );
  end

  // Hold minute and mode alongside the lanes.
  always_ff @(posedge clk) begin
    s6_min    <= s5_min;
    s6_manual <= s5_manual;
    s7_min    <= s6_min;
    s7_manual <= s6_manual;
    s8_min    <= s7_min;
    s8_manual <= s7_manual;
  end

  assign done                 = vld[PIPE_DEPTH-1];
  assign result.minute_of_day = s8_min;
  assign result.red_duty      = lane_duty[CH_RED];
  assign result.white_duty    = lane_duty[CH_WHITE];
  assign result.blue_duty     = lane_duty[CH_BLUE];
  assign result.violet_duty   = lane_duty[CH_VIOLET];
  assign result.manual_mode   = s8_manual;

endmodule

`default_nettype wire

// ===== src/ldsd_port_check.sv =====
// Port-level checker for led_daylight_schedule_dimmer, bound to the top.
// Depends on ldsd_pkg.
`default_nettype none

module ldsd_port_check
  import ldsd_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire item_t   item,
  input wire logic    done,
  input wire result_t result
);

  logic [MIN_W-1:0] clk_min_raw;

  assign clk_min_raw = {6'b0, item.clock_hour} * 11'd60 + {5'b0, item.clock_minute};

  // Every accepted item yields its result after the fixed latency.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("accepted item produced no result");

  // No result without an item accepted the latency earlier.
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without accepted item");

  // Manual flag follows the override reading of the same item.
  a_manual_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.manual_mode == ($past(item.pot_reading, PIPE_DEPTH) != 10'd0)))
    else $error("manual_mode does not match override reading");

  // Clock mode reports the saturated clock minute.
  a_clock_minute: assert property (@(posedge clk) disable iff (rst)
    (done && !result.manual_mode) |->
      (result.minute_of_day == (($past(clk_min_raw, PIPE_DEPTH) > LAST_MINUTE) ?
                                LAST_MINUTE : $past(clk_min_raw, PIPE_DEPTH))))
    else $error("clock minute mismatch");

  // Minute never leaves the day.
  a_minute_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.minute_of_day <= LAST_MINUTE))
    else $error("minute_of_day out of range");

endmodule

bind led_daylight_schedule_dimmer ldsd_port_check u_ldsd_port_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

`default_nettype wire
